// ===== hdl/pel_pkg.sv =====
// Shared types and constants for the positional list engine.
// Depends on nothing. The cell and the top level use it.

package pel_pkg;

  localparam int CAPACITY = 64;
  localparam int CODE_W   = 32;
  localparam int POS_W    = 7;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_RETRIEVE = 2'd2,
    REQ_FIND     = 2'd3
  } pel_req_t;

  typedef struct packed {
    pel_req_t                  req_type;
    logic [POS_W-1:0]          position;
    logic signed [CODE_W-1:0]  code_value;
  } pel_in_t;

  typedef struct packed {
    logic                      ok;
    logic signed [CODE_W-1:0]  code_out;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          list_length;
  } pel_out_t;

  // Broadcast control from the top level to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic               rd;
    logic               fnd;
    logic [CMP_W-1:0]   p;
    logic [CNT_W-1:0]   count;
    logic [CODE_W-1:0]  code;
  } pel_ctl_t;

endpackage

// ===== hdl/positional_list_engine_top.sv =====
// Top level of the positional list engine: control, cell chain and result stage.
// Depends on pel_pkg and pel_cell.

// The engine keeps an ordered list of up to CAPACITY signed 32-bit codes,
// addressed by 1-based position. A request transaction is taken at a rising
// edge where start is high and busy is low; in_item carries the request kind,
// the position and the code. Insert, remove, retrieve and find are supported.
// The list lives in a chain of identical cells, one entry per cell. On the
// accepting edge every cell shifts toward its neighbor for insert or remove,
// and every cell compares its entry against the request and registers a match
// flag and its read data. In the next cycle busy is high while the match flags
// are reduced to the lowest matching position and the read data are ORed
// together. The result transaction then appears on out_item for exactly one
// cycle with out_valid high; out_valid is busy registered once more. A new
// request can be taken in that same result cycle, but none while busy is high,
// so no request is taken while the match flags are reduced over the chain.
// The receiver cannot stall the result, so no buffering follows the strobe.
// Synchronous reset empties the list (the count goes to zero) and clears busy
// and out_valid; the cell contents are left as they are and are never read
// before they are written again.

module positional_list_engine_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pel_pkg::pel_in_t  in_item,
  output logic              out_valid,
  output pel_pkg::pel_out_t out_item
);

  localparam int CAP = pel_pkg::CAPACITY;

  logic                         accept;
  logic [pel_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                         busy_r;
  pel_pkg::pel_req_t            st_kind_r;
  logic                         st_ok_r;
  logic                         out_valid_r;
  pel_pkg::pel_out_t            out_r, out_nxt;

  logic [pel_pkg::POS_W-1:0]    p_pos;
  logic [pel_pkg::CMP_W-1:0]    p_c;
  logic [pel_pkg::CMP_W-1:0]    count_c;
  logic                         pos_nz;
  logic                         ins_ok, rem_ok, rd_ok;
  pel_pkg::pel_ctl_t            ctl;

  logic [pel_pkg::CODE_W-1:0]   entry_w [CAP];
  logic [pel_pkg::CODE_W-1:0]   rd_w    [CAP];
  logic [CAP-1:0]               match_w;

  logic [CAP-1:0]               low_hot;
  logic [pel_pkg::IDX_W-1:0]    hit_idx;
  logic [pel_pkg::CODE_W-1:0]   rd_any;
  logic [31:0]                  found_wide;
  logic [31:0]                  len_wide;

  assign accept = start && !busy_r;

  // Request checks against the list length before this transaction.
  assign pos_nz  = (in_item.position != '0);
  assign p_pos   = in_item.position - pel_pkg::POS_W'(1);
  assign p_c     = pel_pkg::CMP_W'(p_pos);
  assign count_c = pel_pkg::CMP_W'(count_r);
  assign ins_ok  = pos_nz && (p_c <= count_c) && (count_r < pel_pkg::CNT_W'(CAP));
  assign rem_ok  = pos_nz && (p_c < count_c);
  assign rd_ok   = rem_ok;

  always_comb begin
    ctl       = '0;
    ctl.p     = p_c;
    ctl.count = count_r;
    ctl.code  = in_item.code_value;
    if (accept) begin
      case (in_item.req_type)
        pel_pkg::REQ_INSERT:   ctl.ins = ins_ok;
        pel_pkg::REQ_REMOVE:   ctl.rem = rem_ok;
        pel_pkg::REQ_RETRIEVE: ctl.rd  = rd_ok;
        pel_pkg::REQ_FIND:     ctl.fnd = 1'b1;
        default:               ctl.fnd = 1'b0;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + pel_pkg::CNT_W'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - pel_pkg::CNT_W'(1);
    end
  end

  // The cell chain. The first cell's lower neighbor is never selected; the
  // last cell's upper neighbor only refills a slot past the end of the list.
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [pel_pkg::CODE_W-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = ctl.code;
    end else begin : g_mid_lo
      assign prev_w = entry_w[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign next_w = entry_w[g];
    end else begin : g_mid_hi
      assign next_w = entry_w[g+1];
    end
    pel_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (pel_pkg::IDX_W'(g)),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .entry_o (entry_w[g]),
      .match_o (match_w[g]),
      .rd_o    (rd_w[g])
    );
  end

  // Reduction stage: isolate the lowest match, encode it, OR the read data.
  assign low_hot = match_w & (~match_w + CAP'(1));

  always_comb begin
    hit_idx = '0;
    for (int b = 0; b < pel_pkg::IDX_W; b++) begin
      for (int i = 0; i < CAP; i++) begin
        if (((i >> b) & 1) == 1) begin
          hit_idx[b] = hit_idx[b] | low_hot[i];
        end
      end
    end
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAP; i++) begin
      rd_any = rd_any | rd_w[i];
    end
  end

  assign found_wide = 32'(hit_idx) + 32'd1;
  assign len_wide   = 32'(count_r);

  always_comb begin
    out_nxt             = '0;
    out_nxt.list_length = len_wide[pel_pkg::POS_W-1:0];
    out_nxt.code_out    = rd_any;
    if (st_kind_r == pel_pkg::REQ_FIND) begin
      out_nxt.ok = |match_w;
      if (|match_w) begin
        out_nxt.found_position = found_wide[pel_pkg::POS_W-1:0];
      end
    end else begin
      out_nxt.ok = st_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      st_kind_r   <= pel_pkg::REQ_INSERT;
      st_ok_r     <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (accept) begin
        st_kind_r <= in_item.req_type;
        st_ok_r   <= ctl.ins || ctl.rem || ctl.rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // The list never holds more entries than the chain has cells.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pel_pkg::CNT_W'(CAP))
    else $error("list count exceeds capacity");

  // Every accepted request is followed by busy and then by its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 out_valid)
    else $error("result strobe missing after accepted request");

  // A failed request reports neither a code nor a position.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.ok) |->
      (out_item.code_out == '0) && (out_item.found_position == '0))
    else $error("failed request carries data");

endmodule

// ===== hdl/pel_cell.sv =====
// One cell of the list chain: holds one entry and talks to its two neighbors.
// Depends on pel_pkg.

module pel_cell (
  input  logic                          clk,
  input  pel_pkg::pel_ctl_t             ctl,
  input  logic [pel_pkg::IDX_W-1:0]     idx,
  input  logic [pel_pkg::CODE_W-1:0]    prev_i,
  input  logic [pel_pkg::CODE_W-1:0]    next_i,
  output logic [pel_pkg::CODE_W-1:0]    entry_o,
  output logic                          match_o,
  output logic [pel_pkg::CODE_W-1:0]    rd_o
);

  logic [pel_pkg::CODE_W-1:0] entry_r, entry_nxt;
  logic                       match_r, match_nxt;
  logic [pel_pkg::CODE_W-1:0] rd_r, rd_nxt;
  logic [pel_pkg::CMP_W-1:0]  idx_c;
  logic [pel_pkg::CNT_W-1:0]  idx_n;

  assign idx_c = pel_pkg::CMP_W'(idx);
  assign idx_n = pel_pkg::CNT_W'(idx);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (idx_c == ctl.p) begin
        entry_nxt = ctl.code;
      end else if (idx_c > ctl.p) begin
        entry_nxt = prev_i;
      end
    end else if (ctl.rem && (idx_c >= ctl.p)) begin
      entry_nxt = next_i;
    end
  end

  // Search and read act on the contents before this transaction's update.
  assign match_nxt = ctl.fnd && (idx_n < ctl.count) && (entry_r == ctl.code);
  assign rd_nxt    = (ctl.rd && (idx_c == ctl.p)) ? entry_r : '0;

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
    rd_r    <= rd_nxt;
  end

  assign entry_o = entry_r;
  assign match_o = match_r;
  assign rd_o    = rd_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for positional_list_engine_top: directed table plus random traffic.
// Depends on pel_pkg and the engine RTL; it predicts every result with its own list model.

module testbench;
  import pel_pkg::*;

  // The clock period is 8 time units, split into two equal half periods.
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 10;
  // The limit lies far above what a correct run needs.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to keep watching after the last expected result for stray strobes.
  localparam int DRAIN_CYCLES = 8;
  localparam int PLAN_ROWS = 25;
  localparam int RANDOM_ITEMS = 1452;
  localparam int PHASES = 4;
  localparam int SEG_LEN = 121;

  localparam logic [CODE_W-1:0] CODE_MAX = 32'h7fff_ffff;
  localparam logic [CODE_W-1:0] CODE_MIN = 32'h8000_0000;

  // Request mixes used by the random part. Growing mixes fill the list to
  // capacity, shrinking mixes drain it, the even mix keeps it wandering.
  typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_t;

  // One row of the directed table. When pinned is set, the expected result is
  // written into the row and used instead of the predictor's answer.
  typedef struct {
    pel_in_t  req;
    bit       pinned;
    pel_out_t want;
  } plan_entry_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  pel_in_t  in_item = '0;
  logic     out_valid;
  pel_out_t out_item;

  positional_list_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Shadow copy of the list. Only entries below list_depth are ever read, so
  // the contents need no reset, just as in the engine.
  logic [CODE_W-1:0] list_codes [CAPACITY];
  int                list_depth = 0;

  // Results still owed by the engine, oldest first.
  pel_out_t pending_results [$];

  plan_entry_t plan [PLAN_ROWS];
  int idle_pct_by_phase [PHASES] = '{0, 57, 0, 38};

  int mismatches = 0;
  int cycles = 0;
  int results_checked = 0;
  int kind_tally [4] = '{0, 0, 0, 0};
  int deepest = 0;
  int full_rejects = 0;

  // Applies one request to the shadow list and returns the result the engine
  // must produce for it. Failed requests leave the list untouched and report
  // zero for the read data and the match position.
  function automatic pel_out_t list_predict(pel_in_t req);
    pel_out_t res;
    int p;
    res = '0;
    p = req.position;
    case (req.req_type)
      REQ_INSERT: begin
        if (p >= 1 && p <= list_depth + 1 && list_depth < CAPACITY) begin
          for (int i = list_depth; i >= p; i--) list_codes[i] = list_codes[i-1];
          list_codes[p-1] = req.code_value;
          list_depth++;
          res.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (p >= 1 && p <= list_depth) begin
          for (int i = p; i < list_depth; i++) list_codes[i-1] = list_codes[i];
          list_depth--;
          res.ok = 1'b1;
        end
      end
      REQ_RETRIEVE: begin
        if (p >= 1 && p <= list_depth) begin
          res.code_out = list_codes[p-1];
          res.ok = 1'b1;
        end
      end
      default: begin
        // The first match wins, so duplicates report the lowest position.
        for (int i = 0; i < list_depth; i++) begin
          if (!res.ok && list_codes[i] == req.code_value) begin
            res.found_position = POS_W'(i + 1);
            res.ok = 1'b1;
          end
        end
      end
    endcase
    res.list_length = POS_W'(list_depth);
    return res;
  endfunction

  function automatic plan_entry_t plan_row(pel_req_t kind, int pos, logic [CODE_W-1:0] code,
                                           bit pinned, bit ok, logic [CODE_W-1:0] rd,
                                           int found, int len);
    plan_entry_t e;
    e.req.req_type = kind;
    e.req.position = POS_W'(pos);
    e.req.code_value = code;
    e.pinned = pinned;
    e.want.ok = ok;
    e.want.code_out = rd;
    e.want.found_position = POS_W'(found);
    e.want.list_length = POS_W'(len);
    return e;
  endfunction

  // Codes come from a small pool 30 percent of the time so that finds hit and
  // duplicates occur, the extremes 10 percent and fully random words the rest.
  function automatic logic [CODE_W-1:0] pick_code();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return CODE_W'($urandom_range(5)) - 32'd2;
    if (roll < 40) return ($urandom_range(1) != 0) ? CODE_MAX : CODE_MIN;
    return $urandom;
  endfunction

  // Builds one random request from the current shadow list. Most positions
  // fall in the legal range; the rest are anywhere in the 7-bit field.
  function automatic pel_in_t random_request(mix_t mix);
    pel_in_t req;
    int roll;
    int ins_pct;
    int rem_pct;
    int ret_pct;
    bit wild_pos;
    case (mix)
      MIX_GROW:   begin ins_pct = 80; rem_pct = 5;  ret_pct = 8;  end
      MIX_EVEN:   begin ins_pct = 30; rem_pct = 25; ret_pct = 25; end
      default:    begin ins_pct = 10; rem_pct = 60; ret_pct = 15; end
    endcase
    roll = $urandom_range(99);
    wild_pos = ($urandom_range(99) < 15);
    req.code_value = pick_code();
    if (roll < ins_pct) begin
      req.req_type = REQ_INSERT;
      req.position = POS_W'($urandom_range(list_depth + 1, 1));
    end else if (roll < ins_pct + rem_pct) begin
      req.req_type = REQ_REMOVE;
      req.position = POS_W'((list_depth > 0) ? $urandom_range(list_depth, 1) : 1);
    end else if (roll < ins_pct + rem_pct + ret_pct) begin
      req.req_type = REQ_RETRIEVE;
      req.position = POS_W'((list_depth > 0) ? $urandom_range(list_depth, 1) : 1);
    end else begin
      req.req_type = REQ_FIND;
      req.position = POS_W'($urandom_range(127));
      // Half of the searches look for a code that is known to be present.
      if (list_depth > 0 && $urandom_range(1) != 0)
        req.code_value = list_codes[$urandom_range(list_depth - 1)];
    end
    if (wild_pos) req.position = POS_W'($urandom_range(127));
    return req;
  endfunction

  // Offers one request and holds it until the engine takes it. The engine
  // samples start and busy at the same edge this task wakes on, so the edge
  // where busy reads low is the edge of acceptance. After acceptance the
  // sender may go quiet for a random number of cycles.
  task automatic send_request(pel_in_t req, bit pinned, pel_out_t want, int idle_pct);
    pel_out_t predicted;
    start <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req.req_type == REQ_INSERT && list_depth == CAPACITY) full_rejects++;
    predicted = list_predict(req);
    pending_results.push_back(pinned ? want : predicted);
    kind_tally[req.req_type]++;
    if (list_depth > deepest) deepest = list_depth;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic check_field(string name, logic [CODE_W-1:0] want, logic [CODE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker. The strobe lasts one cycle and cannot be held off, so
  // every edge with out_valid high carries one result transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_item);
        mismatches++;
      end else begin
        pel_out_t want;
        want = pending_results.pop_front();
        check_field("ok", CODE_W'(want.ok), CODE_W'(out_item.ok));
        check_field("code_out", want.code_out, out_item.code_out);
        check_field("found_position", CODE_W'(want.found_position),
                    CODE_W'(out_item.found_position));
        check_field("list_length", CODE_W'(want.list_length), CODE_W'(out_item.list_length));
        results_checked++;
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[positional_list_engine_top] ERROR");
      $finish;
    end
  end

  initial begin
    pel_out_t no_result;
    pel_in_t  req;
    mix_t     mix;
    int       phase;
    no_result = '0;

    // The directed table walks the empty list, the extreme codes, positions
    // zero and 127, inserts at the front, middle and end, removes at both
    // ends, a search that ignores a nonzero position, a duplicate code where
    // the first match must win, and searches without a match.
    plan[0]  = plan_row(REQ_RETRIEVE, 1,   32'd0,       1, 0, 32'd0,    0, 0);
    plan[1]  = plan_row(REQ_REMOVE,   1,   32'd0,       1, 0, 32'd0,    0, 0);
    plan[2]  = plan_row(REQ_FIND,     0,   32'd0,       1, 0, 32'd0,    0, 0);
    plan[3]  = plan_row(REQ_INSERT,   0,   32'd5,       1, 0, 32'd0,    0, 0);
    plan[4]  = plan_row(REQ_INSERT,   2,   32'd5,       1, 0, 32'd0,    0, 0);
    plan[5]  = plan_row(REQ_INSERT,   1,   CODE_MAX,    1, 1, 32'd0,    0, 1);
    plan[6]  = plan_row(REQ_INSERT,   1,   CODE_MIN,    1, 1, 32'd0,    0, 2);
    plan[7]  = plan_row(REQ_RETRIEVE, 1,   32'd0,       1, 1, CODE_MIN, 0, 2);
    plan[8]  = plan_row(REQ_RETRIEVE, 2,   32'd0,       1, 1, CODE_MAX, 0, 2);
    plan[9]  = plan_row(REQ_RETRIEVE, 3,   32'd0,       1, 0, 32'd0,    0, 2);
    plan[10] = plan_row(REQ_RETRIEVE, 127, 32'hffff_ffff, 1, 0, 32'd0,  0, 2);
    plan[11] = plan_row(REQ_FIND,     127, CODE_MAX,    1, 1, 32'd0,    2, 2);
    plan[12] = plan_row(REQ_FIND,     0,   32'hffff_ffff, 1, 0, 32'd0,  0, 2);
    plan[13] = plan_row(REQ_INSERT,   3,   32'hffff_ffff, 1, 1, 32'd0,  0, 3);
    plan[14] = plan_row(REQ_INSERT,   2,   32'd0,       0, 0, 32'd0,    0, 0);
    plan[15] = plan_row(REQ_FIND,     127, 32'd0,       0, 0, 32'd0,    0, 0);
    plan[16] = plan_row(REQ_INSERT,   5,   32'd0,       0, 0, 32'd0,    0, 0);
    plan[17] = plan_row(REQ_FIND,     0,   32'd0,       0, 0, 32'd0,    0, 0);
    plan[18] = plan_row(REQ_REMOVE,   0,   32'd0,       1, 0, 32'd0,    0, 5);
    plan[19] = plan_row(REQ_REMOVE,   6,   32'd0,       1, 0, 32'd0,    0, 5);
    plan[20] = plan_row(REQ_REMOVE,   5,   32'd0,       0, 0, 32'd0,    0, 0);
    plan[21] = plan_row(REQ_REMOVE,   1,   32'd0,       0, 0, 32'd0,    0, 0);
    plan[22] = plan_row(REQ_RETRIEVE, 1,   32'd0,       0, 0, 32'd0,    0, 0);
    plan[23] = plan_row(REQ_REMOVE,   127, 32'd0,       1, 0, 32'd0,    0, 3);
    plan[24] = plan_row(REQ_INSERT,   127, 32'h5a5a_5a5a, 1, 0, 32'd0,  0, 3);

    // Synchronous reset, held for a fixed number of cycles and released once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_request(plan[i].req, plan[i].pinned, plan[i].want, 0);

    // Random traffic in four phases; the second and fourth let the sender idle.
    // Within them the request mix cycles through grow, even and shrink segments,
    // so the list is filled to capacity and drained again several times. The
    // result side has no backpressure, so only the sender idles.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n * PHASES) / RANDOM_ITEMS;
      mix = mix_t'((n / SEG_LEN) % 3);
      req = random_request(mix);
      send_request(req, 1'b0, no_result, idle_pct_by_phase[phase]);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d inserts, %0d removes, %0d retrieves, %0d finds.",
             kind_tally[REQ_INSERT] + kind_tally[REQ_REMOVE] + kind_tally[REQ_RETRIEVE]
             + kind_tally[REQ_FIND], kind_tally[REQ_INSERT], kind_tally[REQ_REMOVE],
             kind_tally[REQ_RETRIEVE], kind_tally[REQ_FIND]);
    $display("List reached %0d entries, %0d inserts met a full list, %0d results compared.",
             deepest, full_rejects, results_checked);
    if (mismatches == 0) begin
      $display("[positional_list_engine_top] OK");
    end else begin
      $display("[positional_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule
